@@ rtl/core/ovn_pkg.sv @@
// ----------------------------------------------------------------------------
// ovn_pkg
// Shared types, constants and the cosine weight function for the octave noise.
// ----------------------------------------------------------------------------
package ovn_pkg;

    localparam int POS_W    = 16;
    localparam int SAMPLE_W = 18;
    localparam int LOG2_W   = 4;
    localparam int AMP_W    = 17;
    localparam int PERS_W   = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 17;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;
    localparam int CONTRIB_W  = 51;
    localparam int WEIGHT_W   = 17;
    localparam int NOISE_W    = 33;

    localparam logic [LOG2_W-1:0] MAX_LOG2 = 4'd12;

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    // divisors of the Taylor terms of the cosine: (2n-1)*2n
    localparam logic [63:0] COS_DIV [7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                            64'd90, 64'd132, 64'd182};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_STRIDE_LOG2 = 8'd0,
        CFG_LAST_STRIDE_LOG2  = 8'd1,
        CFG_FIRST_AMPLITUDE   = 8'd2,
        CFG_PERSISTENCE       = 8'd3
    } cfg_index_t;

    // half cosine weight, Q0.16, from an angle in Q30 (elaboration only)
    function automatic logic [WEIGHT_W-1:0] half_weight(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] d;
        x2   = (x * x) >> 30;
        term = Q30_ONE;
        sum  = $signed(Q30_ONE);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / COS_DIV[n-1];
            if (n % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        d = $signed(Q30_ONE) - sum;
        if (d < 0) begin
            d = 64'sd0;
        end
        return WEIGHT_W'((64'(d) + 64'd16384) >> 15);
    endfunction

endpackage

@@ rtl/core/ovn_posmod.sv @@
// ----------------------------------------------------------------------------
// ovn_posmod
// Position modulo tile size: reciprocal multiply, back multiply, one correction.
// ----------------------------------------------------------------------------
module ovn_posmod #(
    parameter int TILE_SIZE = 256,
    parameter int PW        = 8
) (
    input  logic                      aclk,
    input  logic                      ce,
    input  logic [ovn_pkg::POS_W-1:0] pos,
    output logic [PW-1:0]             p
);
    import ovn_pkg::*;

    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / TILE_SIZE);

    logic [47:0]      prod_reg;
    logic [POS_W-1:0] pos1_reg;
    logic [POS_W-1:0] qt_reg;
    logic [POS_W-1:0] pos2_reg;
    logic [PW-1:0]    p_reg;
    logic [28:0]      qt_full;
    logic [POS_W:0]   rem;
    logic [POS_W:0]   rem_fix;

    always_comb begin
        qt_full = 29'(prod_reg[47:32]) * 29'(TILE_SIZE);
        rem     = {1'b0, pos2_reg} - {1'b0, qt_reg};
        rem_fix = (rem >= 17'(TILE_SIZE)) ? rem - 17'(TILE_SIZE) : rem;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg <= 48'(pos) * 48'(RECIP);
            pos1_reg <= pos;
            qt_reg   <= qt_full[POS_W-1:0];
            pos2_reg <= pos1_reg;
            p_reg    <= rem_fix[PW-1:0];
        end
    end

    assign p = p_reg;

endmodule

@@ rtl/core/ovn_lane.sv @@
// ----------------------------------------------------------------------------
// ovn_lane
// One octave: lattice points, hash of both, cosine blend, amplitude scale.
// ----------------------------------------------------------------------------
module ovn_lane #(
    parameter int TILE_SIZE      = 256,
    parameter int WEIGHT_ENTRIES = 64,
    parameter int LANE           = 0,
    parameter int PW             = 8
) (
    input  logic                                 aclk,
    input  logic                                 ce,
    input  logic [PW-1:0]                        p,
    input  logic [ovn_pkg::LOG2_W-1:0]           hi,
    input  logic [ovn_pkg::LOG2_W-1:0]           lo,
    input  logic [ovn_pkg::AMP_W-1:0]            amp,
    output logic signed [ovn_pkg::CONTRIB_W-1:0] contrib
);
    import ovn_pkg::*;

    localparam int IW = $clog2(WEIGHT_ENTRIES);

    logic [PW-1:0]       smod_tab [16];
    logic [WEIGHT_W-1:0] wtab [2**IW];

    for (genvar g = 0; g < 16; g++) begin : g_smod
        localparam int SM = (1 << g) % TILE_SIZE;
        assign smod_tab[g] = PW'(SM);
    end

    for (genvar g = 0; g < 2**IW; g++) begin : g_wt
        if (g < WEIGHT_ENTRIES) begin : g_on
            localparam int J = (2 * g <= WEIGHT_ENTRIES) ? g : WEIGHT_ENTRIES - g;
            localparam logic [63:0] X = (PI_Q30 * 64'(J)) / WEIGHT_ENTRIES;
            localparam logic [WEIGHT_W-1:0] HW = half_weight(X);
            assign wtab[g] = (2 * g <= WEIGHT_ENTRIES) ? HW : 17'd65536 - HW;
        end else begin : g_off
            assign wtab[g] = '0;
        end
    end

    // stage 4: lattice decode
    logic signed [5:0] kk;
    logic              act_c;
    logic [3:0]        k;
    logic [15:0]       mask;
    logic [15:0]       off;
    logic [PW-1:0]     a_c;
    logic [PW:0]       b_sum;
    logic [PW-1:0]     b_c;
    logic [21:0]       ip;
    logic [21:0]       idx_c;

    always_comb begin
        kk    = $signed({2'b00, hi}) - 6'(LANE);
        act_c = (kk >= $signed({2'b00, lo}));
        k     = kk[3:0];
        mask  = (16'd1 << k) - 16'd1;
        off   = 16'(p) & mask;
        a_c   = p - off[PW-1:0];
        b_sum = {1'b0, a_c} + {1'b0, smod_tab[k]};
        b_c   = (b_sum >= (PW+1)'(TILE_SIZE)) ? PW'(b_sum - (PW+1)'(TILE_SIZE))
                                               : b_sum[PW-1:0];
        ip    = 22'(off[12:0]) * 22'(WEIGHT_ENTRIES);
        idx_c = ip >> k;
    end

    logic [PW-1:0] a4_reg, b4_reg;
    logic [IW-1:0] idx4_reg, idx5_reg;
    logic          act4_reg, act5_reg, act6_reg, act7_reg, act8_reg;

    // stage 5: x and x*x
    logic [31:0] xa_c, xb_c;
    logic [31:0] xa5_reg, xb5_reg, xxa5_reg, xxb5_reg;
    assign xa_c = 32'(a4_reg) ^ (32'(a4_reg) << 13);
    assign xb_c = 32'(b4_reg) ^ (32'(b4_reg) << 13);

    // stage 6: polynomial inner term, weight lookup
    logic [31:0]         xa6_reg, xb6_reg, ta6_reg, tb6_reg;
    logic [WEIGHT_W-1:0] w6_reg, w7_reg;

    // stage 7: hash finish, noise Q1.30
    logic [31:0]               va_c, vb_c;
    logic signed [NOISE_W-1:0] na7_reg, nb7_reg;
    assign va_c = xa6_reg * ta6_reg + 32'd1376312589;
    assign vb_c = xb6_reg * tb6_reg + 32'd1376312589;

    // stage 8: blend
    logic signed [NOISE_W:0]   diff;
    logic signed [51:0]        bprod;
    logic signed [51:0]        bsum;
    logic signed [NOISE_W-1:0] blend8_reg;

    always_comb begin
        diff  = 34'(nb7_reg) - 34'(na7_reg);
        bprod = 52'(diff) * 52'($signed({1'b0, w7_reg}));
        bsum  = (52'(na7_reg) <<< 16) + bprod + 52'sd32768;
    end

    // stage 9: amplitude
    logic signed [CONTRIB_W-1:0] c9_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            a4_reg     <= a_c;
            b4_reg     <= b_c;
            idx4_reg   <= idx_c[IW-1:0];
            act4_reg   <= act_c;
            xa5_reg    <= xa_c;
            xb5_reg    <= xb_c;
            xxa5_reg   <= xa_c * xa_c;
            xxb5_reg   <= xb_c * xb_c;
            idx5_reg   <= idx4_reg;
            act5_reg   <= act4_reg;
            xa6_reg    <= xa5_reg;
            xb6_reg    <= xb5_reg;
            ta6_reg    <= xxa5_reg * 32'd15731 + 32'd789221;
            tb6_reg    <= xxb5_reg * 32'd15731 + 32'd789221;
            w6_reg     <= wtab[idx5_reg];
            act6_reg   <= act5_reg;
            na7_reg    <= 33'sd1073741824 - $signed({2'b00, va_c[30:0]});
            nb7_reg    <= 33'sd1073741824 - $signed({2'b00, vb_c[30:0]});
            w7_reg     <= w6_reg;
            act7_reg   <= act6_reg;
            blend8_reg <= bsum[48:16];
            act8_reg   <= act7_reg;
            c9_reg     <= act8_reg ? CONTRIB_W'(blend8_reg) *
                                     CONTRIB_W'($signed({1'b0, amp}))
                                   : '0;
        end
    end

    assign contrib = c9_reg;

endmodule

@@ rtl/core/ovn_sum.sv @@
// ----------------------------------------------------------------------------
// ovn_sum
// Registered adder tree over the octaves, then rounding and saturation.
// ----------------------------------------------------------------------------
module ovn_sum #(
    parameter int NL = 8
) (
    input  logic                                 aclk,
    input  logic                                 ce,
    input  logic signed [ovn_pkg::CONTRIB_W-1:0] contrib [NL],
    output logic [ovn_pkg::SAMPLE_W-1:0]         sample
);
    import ovn_pkg::*;

    localparam int NG = (NL + 3) / 4;
    localparam int SW = 56;

    logic signed [SW-1:0] grp_c   [NG];
    logic signed [SW-1:0] grp_reg [NG];
    logic signed [SW-1:0] tot_c;
    logic signed [SW-1:0] tot_reg;
    logic signed [SW-1:0] rnd;
    logic signed [SW-1:0] res;
    logic [SAMPLE_W-1:0]  sample_reg;
    logic [SAMPLE_W-1:0]  sat_c;

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            grp_c[g] = '0;
            for (int i = 0; i < 4; i++) begin
                if (4 * g + i < NL) begin
                    grp_c[g] = grp_c[g] + SW'(contrib[4*g+i]);
                end
            end
        end
        tot_c = '0;
        for (int g = 0; g < NG; g++) begin
            tot_c = tot_c + grp_reg[g];
        end
        rnd = tot_reg + 56'sd536870912;
        res = rnd >>> 30;
        if (res > 56'sd131071) begin
            sat_c = 18'h1FFFF;
        end else if (res < -56'sd131072) begin
            sat_c = 18'h20000;
        end else begin
            sat_c = res[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            grp_reg    <= grp_c;
            tot_reg    <= tot_c;
            sample_reg <= sat_c;
        end
    end

    assign sample = sample_reg;

endmodule

@@ rtl/core/octave_value_noise_1d.sv @@
// ----------------------------------------------------------------------------
// octave_value_noise_1d
// Tileable fractal 1D value noise, cosine blended, summed over octaves.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata[15:0]  position
//  m_       out  m_tvalid/m_tready    m_tdata[17:0]  sample (signed Q2.16)
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One beat in per cycle while s_tready is high; every octave has its
//  own lane, so the rate does not depend on the octave count.
//  After reset and after each config write the amplitude chain settles
//  while settle_reg counts down (one register per octave); s_tready is low then.
//  A stall on m_ freezes the whole pipeline; nothing is dropped.
//  aresetn is synchronous, active low; config returns to its reset values.
// ----------------------------------------------------------------------------
module octave_value_noise_1d #(
    parameter int TILE_SIZE      = 256,
    parameter int MAX_OCTAVES    = 8,
    parameter int WEIGHT_ENTRIES = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ovn_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] position
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ovn_pkg::M_TDATA_W-1:0]    m_tdata,   // [17:0] sample, rest zero
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ovn_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ovn_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ovn_pkg::*;

    localparam int PW  = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
    localparam int LAT = 12;
    localparam int STW = $clog2(MAX_OCTAVES + 1);

    // config registers
    logic [LOG2_W-1:0] first_log2_reg, last_log2_reg;
    logic [AMP_W-1:0]  first_amp_reg;
    logic [PERS_W-1:0] pers_reg;
    logic              cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_log2_reg <= 4'd6;
            last_log2_reg  <= 4'd1;
            first_amp_reg  <= 17'd65536;
            pers_reg       <= 16'd32768;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                CFG_FIRST_STRIDE_LOG2: first_log2_reg <= cfg_data[LOG2_W-1:0];
                CFG_LAST_STRIDE_LOG2:  last_log2_reg  <= cfg_data[LOG2_W-1:0];
                CFG_FIRST_AMPLITUDE:   first_amp_reg  <= cfg_data[AMP_W-1:0];
                CFG_PERSISTENCE:       pers_reg       <= cfg_data[PERS_W-1:0];
                default: ;
            endcase
        end
    end

    logic [LOG2_W-1:0] hi, lo;
    assign hi = (first_log2_reg > MAX_LOG2) ? MAX_LOG2 : first_log2_reg;
    assign lo = (last_log2_reg > MAX_LOG2) ? MAX_LOG2 : last_log2_reg;

    // amplitude per octave: one multiply per link, refreshed every cycle
    logic [AMP_W-1:0] amp_reg [MAX_OCTAVES];
    logic [STW-1:0]   settle_reg;

    always_ff @(posedge aclk) begin
        amp_reg[0] <= first_amp_reg;
        for (int j = 1; j < MAX_OCTAVES; j++) begin
            amp_reg[j] <= AMP_W'((33'(amp_reg[j-1]) * 33'(pers_reg) + 33'd32768) >> 16);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr) begin
            settle_reg <= STW'(MAX_OCTAVES);
        end else if (settle_reg != '0) begin
            settle_reg <= settle_reg - STW'(1);
        end
    end

    // pipeline control
    logic           ce;
    logic [LAT-1:0] vld_reg;

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce && (settle_reg == '0);
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid & s_tready};
        end
    end

    // datapath
    logic [PW-1:0]               p;
    logic signed [CONTRIB_W-1:0] contrib [MAX_OCTAVES];
    logic [SAMPLE_W-1:0]         sample;

    ovn_posmod #(.TILE_SIZE(TILE_SIZE), .PW(PW)) u_posmod (
        .aclk (aclk),
        .ce   (ce),
        .pos  (s_tdata[POS_W-1:0]),
        .p    (p)
    );

    for (genvar j = 0; j < MAX_OCTAVES; j++) begin : g_lane
        ovn_lane #(
            .TILE_SIZE      (TILE_SIZE),
            .WEIGHT_ENTRIES (WEIGHT_ENTRIES),
            .LANE           (j),
            .PW             (PW)
        ) u_lane (
            .aclk    (aclk),
            .ce      (ce),
            .p       (p),
            .hi      (hi),
            .lo      (lo),
            .amp     (amp_reg[j]),
            .contrib (contrib[j])
        );
    end

    ovn_sum #(.NL(MAX_OCTAVES)) u_sum (
        .aclk    (aclk),
        .ce      (ce),
        .contrib (contrib),
        .sample  (sample)
    );

    assign m_tdata = M_TDATA_W'(sample);

endmodule

@@ rtl/core/ovn_checker.sv @@
// ----------------------------------------------------------------------------
// ovn_checker
// Port-level checks on the noise block, bound to the top level.
// ----------------------------------------------------------------------------
module ovn_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ovn_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          cfg_valid,
    input logic                          cfg_ready
);
    import ovn_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_tready)
        else $error("input taken while amplitudes settle");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("pipeline not empty after reset");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:SAMPLE_W] == '0)
        else $error("tdata padding not zero");

endmodule

bind octave_value_noise_1d ovn_checker u_ovn_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

@@ tb/sv/octave_value_noise_1d_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// octave_value_noise_1d_test
// Self-checking bench for the octave value noise block. Positions stream in
// on s_, samples come back on m_; each sample is checked against the value
// typed in its row or a local fixed point noise predictor run when the beat
// is taken. A short directed table covers extremes and corner cases, then
// random phases with random register settings, random idling on both sides.
// ----------------------------------------------------------------------------
module octave_value_noise_1d_test;
    import ovn_pkg::*;

    localparam int TILE       = 256;
    localparam int OCTAVE_CAP = 8;
    localparam int WEIGHT_N   = 64;
    localparam int DRAIN_CYC  = 40;          // > pipeline latency plus settle
    localparam int RANDOM_ITEMS = 1550;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd7;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_POS
    } row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic [POS_W-1:0]        pos;
        bit                      fixed_exp;  // expected typed in the row
        logic [SAMPLE_W-1:0]     exp;
    } stim_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata = '0;   // [15:0] position
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;        // [17:0] sample, rest zero
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    // register mirror
    logic [LOG2_W-1:0] mir_first;
    logic [LOG2_W-1:0] mir_last;
    logic [AMP_W-1:0]  mir_amp;
    logic [PERS_W-1:0] mir_pers;

    logic [SAMPLE_W-1:0] pending_samples[$];
    stim_row_t           rows[$];
    int                  fail_count = 0;

    always #1 aclk = ~aclk;

    octave_value_noise_1d uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // ---------------------------------------------------------------- predictor
    // lattice hash, Q1.30 noise in (-1, 1]
    function automatic longint lattice_noise(input logic [31:0] n);
        logic [31:0] x;
        logic [31:0] v;
        x = (n << 13) ^ n;
        v = (x * (x * x * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
        return longint'(Q30_ONE) - longint'({32'd0, v});
    endfunction

    // (1 - cos) / 2 style weight for the first half of the segment, Q0.16
    function automatic logic [31:0] rising_weight(input logic [63:0] i);
        logic [63:0] ang;
        logic [63:0] ang2;
        logic [63:0] term;
        longint      cosv;
        longint      d;
        ang  = (PI_Q30 * i) / WEIGHT_N;
        ang2 = (ang * ang) >> 30;
        term = Q30_ONE;
        cosv = longint'(Q30_ONE);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * ang2) >> 30) / ((2 * n - 1) * (2 * n));
            if (n % 2 == 1) cosv = cosv - longint'(term);
            else            cosv = cosv + longint'(term);
        end
        d = longint'(Q30_ONE) - cosv;
        if (d < 0) d = 0;
        return 32'((64'(d) + 64'd16384) >> 15);
    endfunction

    function automatic longint blend_weight(input logic [63:0] i);
        if (2 * i <= WEIGHT_N) return longint'(rising_weight(i));
        return 65536 - longint'(rising_weight(WEIGHT_N - i));
    endfunction

    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [SAMPLE_W-1:0] noise_sample(input logic [POS_W-1:0] position);
        logic [63:0] p;
        logic [63:0] amp;
        logic [63:0] stride;
        logic [63:0] off;
        logic [63:0] lat_a;
        logic [63:0] lat_b;
        int          hi;
        int          lo;
        int          octaves;
        longint      na;
        longint      nb;
        longint      blend;
        longint      acc;
        longint      res;
        p   = 64'(position) % TILE;
        hi  = (mir_first > MAX_LOG2) ? int'(MAX_LOG2) : int'(mir_first);
        lo  = (mir_last > MAX_LOG2) ? int'(MAX_LOG2) : int'(mir_last);
        amp = 64'(mir_amp);
        acc = 0;
        octaves = 0;
        for (int k = hi; k >= lo && octaves < OCTAVE_CAP; k--) begin
            stride = 64'd1 << k;
            off    = p & (stride - 1);
            lat_a  = p - off;
            lat_b  = (lat_a + stride) % TILE;
            na     = lattice_noise(lat_a[31:0]);
            nb     = lattice_noise(lat_b[31:0]);
            blend  = round_shift(na * 65536 + (nb - na) * blend_weight((off * WEIGHT_N) >> k), 16);
            acc    = acc + blend * longint'(amp);
            amp    = (amp * 64'(mir_pers) + 64'd32768) >> 16;
            octaves++;
        end
        res = round_shift(acc, 30);
        if (res > 131071)  res = 131071;
        if (res < -131072) res = -131072;
        return res[SAMPLE_W-1:0];
    endfunction

    // ---------------------------------------------------------------- drivers
    task automatic wait_idle();
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    // registers are only written with nothing in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FIRST_STRIDE_LOG2: mir_first = val[LOG2_W-1:0];
            CFG_LAST_STRIDE_LOG2:  mir_last  = val[LOG2_W-1:0];
            CFG_FIRST_AMPLITUDE:   mir_amp   = val[AMP_W-1:0];
            CFG_PERSISTENCE:       mir_pers  = val[PERS_W-1:0];
            default: ;
        endcase
    endtask

    // one position beat; valid stays high across back-to-back beats
    task automatic send_position(input logic [POS_W-1:0] pos, input bit fixed_exp,
                                 input logic [SAMPLE_W-1:0] exp);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;   // bursts without gaps
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pos;
        do @(posedge aclk); while (!s_tready);
        pending_samples.push_back(fixed_exp ? exp : noise_sample(pos));
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        rows.push_back('{ROW_CFG, idx, val, '0, 1'b0, '0});
    endtask

    task automatic add_pos(input logic [POS_W-1:0] pos, input bit fixed_exp,
                           input logic [SAMPLE_W-1:0] exp);
        rows.push_back('{ROW_POS, '0, '0, pos, fixed_exp, exp});
    endtask

    // ---------------------------------------------------------------- checker
    initial begin
        logic [SAMPLE_W-1:0] want;
        int gap;
        @(posedge aresetn);
        forever begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (pending_samples.size() == 0) begin
                $error("sample beat with nothing expected: actual %0d",
                       $signed(m_tdata[SAMPLE_W-1:0]));
                fail_count++;
            end else begin
                want = pending_samples.pop_front();
                if (m_tdata[SAMPLE_W-1:0] !== want) begin
                    $error("sample: expected %0d actual %0d", $signed(want),
                           $signed(m_tdata[SAMPLE_W-1:0]));
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    initial begin
        int phase_len;
        int sent;
        mir_first = 4'd6;
        mir_last  = 4'd1;
        mir_amp   = 17'd65536;
        mir_pers  = 16'd32768;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        add_pos(16'd0, 1'b0, '0);                 // reset settings
        add_pos(16'd255, 1'b0, '0);
        add_pos(16'd256, 1'b0, '0);               // wraps to 0
        add_pos(16'hFFFF, 1'b0, '0);
        add_pos(16'h8000, 1'b0, '0);
        add_pos(16'd97, 1'b0, '0);
        add_cfg(CFG_FIRST_STRIDE_LOG2, 17'd8);    // nine octaves, capped
        add_cfg(CFG_LAST_STRIDE_LOG2, 17'd0);
        add_pos(16'd1, 1'b0, '0);
        add_pos(16'd200, 1'b0, '0);
        add_cfg(CFG_FIRST_STRIDE_LOG2, 17'h1FFFF); // masks to 15, clamps to 12
        add_cfg(CFG_LAST_STRIDE_LOG2, 17'd9);      // strides beyond the tile
        add_pos(16'd77, 1'b0, '0);
        add_pos(16'd255, 1'b0, '0);
        add_cfg(CFG_FIRST_AMPLITUDE, 17'h1FFFF);
        add_cfg(CFG_PERSISTENCE, 17'hFFFF);
        add_cfg(CFG_LAST_STRIDE_LOG2, 17'd0);      // full chain, may saturate
        add_pos(16'd3, 1'b0, '0);
        add_pos(16'd130, 1'b0, '0);
        add_cfg(CFG_UNUSED_IDX, 17'h1FFFF);        // must be ignored
        add_pos(16'd44, 1'b0, '0);
        add_cfg(CFG_FIRST_AMPLITUDE, 17'd0);       // zero amplitude
        add_pos(16'd123, 1'b1, 18'd0);
        add_cfg(CFG_FIRST_AMPLITUDE, 17'd65536);
        add_cfg(CFG_FIRST_STRIDE_LOG2, 17'd2);     // finest above coarsest
        add_cfg(CFG_LAST_STRIDE_LOG2, 17'd5);
        add_pos(16'd250, 1'b1, 18'd0);

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_CFG) write_reg(rows[r].idx, rows[r].data);
            else send_position(rows[r].pos, rows[r].fixed_exp, rows[r].exp);
        end

        // random phases, each with its own register set
        sent = 0;
        for (int ph = 0; sent < RANDOM_ITEMS; ph++) begin
            logic [CFG_DATA_W-1:0] v;
            v = (ph % 5 == 1) ? 17'd8 : 17'($urandom_range(1, 8));
            if ($urandom_range(0, 7) == 0) v = 17'($urandom);
            write_reg(CFG_FIRST_STRIDE_LOG2, v);
            v = (ph % 5 == 1) ? 17'd0 : 17'($urandom_range(0, 8));
            if ($urandom_range(0, 7) == 0) v = 17'($urandom);
            write_reg(CFG_LAST_STRIDE_LOG2, v);
            case (ph % 5)
                1:       v = 17'h1FFFF;
                2:       v = 17'd0;
                default: v = 17'($urandom);
            endcase
            write_reg(CFG_FIRST_AMPLITUDE, v);
            case (ph % 5)
                1:       v = 17'hFFFF;
                3:       v = 17'd0;
                default: v = 17'($urandom);
            endcase
            write_reg(CFG_PERSISTENCE, v);
            if (ph % 4 == 0) write_reg(8'($urandom_range(4, 255)), 17'($urandom));
            phase_len = $urandom_range(60, 140);
            for (int n = 0; n < phase_len; n++) begin
                send_position(16'($urandom), 1'b0, '0);
                sent++;
                if (n == phase_len / 2 && ph % 3 == 0) begin
                    // hold the sender until the pipe has fully drained
                    s_tvalid <= 1'b0;
                    while (pending_samples.size() != 0) @(posedge aclk);
                end
            end
        end
        s_tvalid <= 1'b0;

        wait_idle();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/ovn_pkg.sv
rtl/core/ovn_posmod.sv
rtl/core/ovn_lane.sv
rtl/core/ovn_sum.sv
rtl/core/octave_value_noise_1d.sv
rtl/core/ovn_checker.sv
tb/sv/octave_value_noise_1d_test.sv
